// ----- hdl/wpem_pkg.sv -----
// ----------------------------------------------------------------------------
// wpem_pkg
// Types, constants and byte-class helpers shared by the word prefix
// emphasis marker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wpem_pkg;

    localparam int HOLD_DEPTH = 8;
    localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
    // word length counter holds 0..HOLD_DEPTH
    localparam int LEN_W      = HOLD_AW + 1;
    localparam int FOCUS_W    = 3;

    localparam logic [7:0] APOSTROPHE = 8'h27;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
    } text_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       emphasised;
        logic       segment_start;
        logic       last_of_line;
    } mark_item_t;

    typedef enum logic [1:0] {
        CLS_LINE_START,
        CLS_WORD,
        CLS_OTHER
    } byte_class_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } wpem_state_t;

    typedef struct packed {
        logic load;
        logic emit;
    } wpem_cmd_t;

    typedef struct packed {
        logic more;
        logic final_step;
        logic room;
    } wpem_status_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alnum(c) || (c == APOSTROPHE);
    endfunction

    // clamp((2n+4)/5, 1, 4) for n in 0..8
    function automatic logic [FOCUS_W-1:0] focus_len(input logic [LEN_W-1:0] n);
        logic [FOCUS_W-1:0] f;
        case (n)
            4'd0, 4'd1, 4'd2:       f = 3'd1;
            4'd3, 4'd4, 4'd5:       f = 3'd2;
            4'd6, 4'd7:             f = 3'd3;
            default:                f = 3'd4;
        endcase
        return f;
    endfunction

    // leading word bytes whose flags are known before the word ends
    function automatic logic [LEN_W-1:0] settled_count(input logic [LEN_W-1:0] n,
                                                        input logic a);
        logic [LEN_W-1:0] s;
        if (n >= LEN_W'(HOLD_DEPTH))
            s = n;
        else if (a && n >= LEN_W'(2))
            s = LEN_W'(focus_len(n));
        else
            s = '0;
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/wpem_stream_if.sv -----
// ----------------------------------------------------------------------------
// wpem_stream_if
// Valid/ready stream channel carrying one payload struct per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpem_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/word_prefix_emphasis_marker_unit.sv -----
// ----------------------------------------------------------------------------
// word_prefix_emphasis_marker_unit
// Passes a text line through byte by byte, flagging emphasised word prefixes
// and segment starts.
// ----------------------------------------------------------------------------
// Usage:
//   text_ch carries one byte of a line per transaction, with line_end on the
//   final byte. mark_ch returns every byte in original order with its
//   emphasised, segment_start and last_of_line flags.
//   Word bytes are held in an 8-entry buffer until their flags are settled,
//   so one input byte gives zero to eight results.
//   Timing: a byte is taken while the sequencer is idle; its results then
//   leave one per cycle through the output register while it has room, the
//   sequencer returning ready with the last one. The output register drains
//   at one result per cycle while mark_ch is ready.
//   Output stall: while the output register is full and not taken, result
//   emission pauses and no new byte is accepted beyond the one in progress.
//   Reset: word state clears to line start, the output register empties;
//   the hold buffer needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module word_prefix_emphasis_marker_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wpem_stream_if.sink   text_ch,
    wpem_stream_if.source mark_ch
);

    wpem_pkg::wpem_cmd_t    cmd;
    wpem_pkg::wpem_status_t status;

    wpem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text_ch.valid),
        .status   (status),
        .cmd      (cmd),
        .in_ready (text_ch.ready)
    );

    wpem_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (text_ch.payload),
        .out_ready (mark_ch.ready),
        .status    (status),
        .out_valid (mark_ch.valid),
        .out_item  (mark_ch.payload)
    );

endmodule

`default_nettype wire

// ----- hdl/wpem_ctrl.sv -----
// ----------------------------------------------------------------------------
// wpem_ctrl
// Controller: takes one byte, then steps the datapath through its results.
// ----------------------------------------------------------------------------
`default_nettype none

module wpem_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire wpem_pkg::wpem_status_t status,
    output wpem_pkg::wpem_cmd_t        cmd,
    output logic                       in_ready
);

    wpem_pkg::wpem_state_t state_reg;
    wpem_pkg::wpem_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wpem_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wpem_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = wpem_pkg::ST_EMIT;
            end
            wpem_pkg::ST_EMIT:
            begin
                // byte held back entirely, or its last result going out now
                if (!status.more)
                    state_next = wpem_pkg::ST_IDLE;
                else if (status.room && status.final_step)
                    state_next = wpem_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wpem_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            wpem_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            wpem_pkg::ST_EMIT:
            begin
                cmd.emit = status.more && status.room;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/wpem_dpath.sv -----
// ----------------------------------------------------------------------------
// wpem_dpath
// Datapath: word hold buffer, word state, release range and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wpem_dpath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wpem_pkg::wpem_cmd_t    cmd,
    input  wire wpem_pkg::text_item_t   in_item,
    input  wire logic                   out_ready,
    output wpem_pkg::wpem_status_t      status,
    output logic                        out_valid,
    output wpem_pkg::mark_item_t        out_item
);

    localparam int LW = wpem_pkg::LEN_W;
    localparam int FW = wpem_pkg::FOCUS_W;
    localparam int AW = wpem_pkg::HOLD_AW;

    logic [7:0] held_mem [wpem_pkg::HOLD_DEPTH];

    // word state
    logic [LW-1:0]          len_reg,    len_next;
    logic                   alnum_reg,  alnum_next;
    wpem_pkg::byte_class_t  prev_reg,   prev_next;

    // release plan for the current transaction
    logic [LW-1:0]          idx_reg,    idx_next;
    logic [LW-1:0]          to_reg,     to_next;
    logic [FW-1:0]          focus_reg,  focus_next;
    logic                   split_reg,  split_next;
    logic                   direct_reg, direct_next;
    logic                   dstart_reg, dstart_next;
    logic [7:0]             dbyte_reg,  dbyte_next;
    logic                   end_reg,    end_next;

    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg;
    logic                   emph_reg,      emph_next;
    logic                   sstart_reg,    sstart_next;
    logic                   last_reg,      last_next;

    logic                   hold_wr;
    logic                   word_c;
    logic                   alnum_c;
    logic                   full;
    logic [LW-1:0]          len_inc;
    logic                   alnum_upd;
    logic [LW-1:0]          judge_len;
    logic                   judge_alnum;
    logic                   from_held;
    logic [LW-1:0]          idx_inc;

    assign word_c    = wpem_pkg::is_word(in_item.text_byte);
    assign alnum_c   = wpem_pkg::is_alnum(in_item.text_byte);
    assign full      = (len_reg >= LW'(wpem_pkg::HOLD_DEPTH));
    assign len_inc   = len_reg + LW'(1);
    assign alnum_upd = alnum_reg | alnum_c;
    assign from_held = (idx_reg < to_reg);
    assign idx_inc   = idx_reg + LW'(1);

    assign status.more       = from_held || direct_reg;
    assign status.final_step = from_held ? ((idx_inc == to_reg) && !direct_reg) : direct_reg;
    assign status.room       = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_item  = '{out_byte:      out_byte_reg,
                         emphasised:    emph_reg,
                         segment_start: sstart_reg,
                         last_of_line:  last_reg};

    // hold buffer, and the byte of the result being emitted
    always_ff @(posedge clk)
    begin
        if (hold_wr)
            held_mem[len_reg[AW-1:0]] <= in_item.text_byte;
        if (cmd.emit)
            out_byte_reg <= from_held ? held_mem[idx_reg[AW-1:0]] : dbyte_reg;
    end

    always_comb
    begin
        len_next       = len_reg;
        alnum_next     = alnum_reg;
        prev_next      = prev_reg;
        idx_next       = idx_reg;
        to_next        = to_reg;
        focus_next     = focus_reg;
        split_next     = split_reg;
        direct_next    = direct_reg;
        dstart_next    = dstart_reg;
        dbyte_next     = dbyte_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg;
        emph_next      = emph_reg;
        sstart_next    = sstart_reg;
        last_next      = last_reg;
        hold_wr        = 1'b0;
        judge_len      = len_reg;
        judge_alnum    = alnum_reg;

        if (cmd.load)
        begin
            dbyte_next  = in_item.text_byte;
            end_next    = in_item.line_end;
            dstart_next = 1'b0;
            if (word_c && !full)
            begin
                hold_wr     = 1'b1;
                idx_next    = wpem_pkg::settled_count(len_reg, alnum_reg);
                to_next     = in_item.line_end ? len_inc
                                               : wpem_pkg::settled_count(len_inc, alnum_upd);
                judge_len   = len_inc;
                judge_alnum = alnum_upd;
                direct_next = 1'b0;
                len_next    = len_inc;
                alnum_next  = alnum_upd;
                prev_next   = wpem_pkg::CLS_WORD;
            end
            else if (word_c)
            begin
                // long word tail goes straight through, plain
                idx_next    = '0;
                to_next     = '0;
                direct_next = 1'b1;
                alnum_next  = alnum_upd;
                prev_next   = wpem_pkg::CLS_WORD;
            end
            else
            begin
                // word ended: release what is still held, then the byte itself
                if (len_reg != '0 && !full)
                begin
                    idx_next = wpem_pkg::settled_count(len_reg, alnum_reg);
                    to_next  = len_reg;
                end
                else
                begin
                    idx_next = '0;
                    to_next  = '0;
                end
                direct_next = 1'b1;
                dstart_next = (prev_reg != wpem_pkg::CLS_OTHER);
                len_next    = '0;
                alnum_next  = 1'b0;
                prev_next   = wpem_pkg::CLS_OTHER;
            end
            split_next = judge_alnum && (judge_len >= LW'(2));
            focus_next = split_next ? wpem_pkg::focus_len(judge_len) : '0;
            if (in_item.line_end)
            begin
                len_next   = '0;
                alnum_next = 1'b0;
                prev_next  = wpem_pkg::CLS_LINE_START;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (from_held)
            begin
                emph_next   = (idx_reg < LW'(focus_reg));
                sstart_next = (idx_reg == '0) ||
                              (split_reg && idx_reg == LW'(focus_reg));
                last_next   = end_reg && !direct_reg && (idx_inc == to_reg);
                idx_next    = idx_inc;
            end
            else
            begin
                emph_next   = 1'b0;
                sstart_next = dstart_reg;
                last_next   = end_reg;
                direct_next = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            alnum_reg     <= 1'b0;
            prev_reg      <= wpem_pkg::CLS_LINE_START;
            idx_reg       <= '0;
            to_reg        <= '0;
            direct_reg    <= 1'b0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            alnum_reg     <= alnum_next;
            prev_reg      <= prev_next;
            idx_reg       <= idx_next;
            to_reg        <= to_next;
            direct_reg    <= direct_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        focus_reg  <= focus_next;
        split_reg  <= split_next;
        dstart_reg <= dstart_next;
        dbyte_reg  <= dbyte_next;
        emph_reg   <= emph_next;
        sstart_reg <= sstart_next;
        last_reg   <= last_next;
    end

endmodule

`default_nettype wire
